>>> hdl/windowed_zscore_anomaly_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the windowed z-score anomaly detector
// Shared same-cycle-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_ZSCORE_ANOMALY_DETECTOR_DEFINES_SVH
`define WINDOWED_ZSCORE_ANOMALY_DETECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZSC_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/zsc_pkg.sv
// ----------------------------------------------------------------------------
// zsc_pkg
// Widths, constants and shared types of the windowed z-score detector.
// ----------------------------------------------------------------------------
package zsc_pkg;

   // window of stored sample pairs
   localparam int WINDOW = 10;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = $clog2(WINDOW);

   localparam int SMP_W  = 16;
   localparam int SUM_W  = SMP_W + 1 + CNT_W;        // signed window sum
   localparam int MW     = SUM_W + 1;                // multiplier operand width
   localparam int QW     = 2 * SMP_W + CNT_W;        // unsigned sum of squares
   localparam int LO_W   = MW - 1;                   // low slice of sum of squares
   localparam int HI_W   = QW - LO_W;                // high slice of sum of squares
   localparam int VW     = 2 * CNT_W + 2 * SMP_W + 2; // signed n*Q - S*S
   localparam int DW     = 2 * MW - 1;               // unsigned (n*x - S)^2

   localparam int SCORE_W  = 16;
   localparam int SCALE_SH = 11;                     // 2048 = Q4.12 halved
   localparam int SAT_SH   = SCORE_W - SCALE_SH;
   localparam int STEP_W   = $clog2(SCORE_W + 1);
   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   localparam int MIN_W   = 4;
   localparam int CMP_W   = (CNT_W > MIN_W) ? CNT_W : MIN_W;

   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(WINDOW);

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAMPLES = 1'b1;
   localparam logic [SCORE_W-1:0]   LIMIT_RESET     = 16'd16384;
   localparam logic [MIN_W-1:0]     MIN_RESET       = 4'd5;

   localparam int REQ_DATA_W = 2 * SMP_W;
   localparam int RSP_DATA_W = 24;
   localparam int RAM_W      = 2 * SMP_W;

   typedef struct packed {
      logic                busy;
      logic [SCORE_W-1:0]  quotient;
   } div_result_type;

endpackage

>>> hdl/zsc_ram.sv
// ----------------------------------------------------------------------------
// zsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module zsc_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/zsc_div.sv
// ----------------------------------------------------------------------------
// zsc_div
// Serial restoring divider: floor(2048 * D / V), saturated, 0 for V <= 0.
// ----------------------------------------------------------------------------
module zsc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [zsc_pkg::DW-1:0]          dsq,
   input  logic signed [zsc_pkg::VW-1:0]   var_n2,
   output zsc_pkg::div_result_type         result
);
   import zsc_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} state_type;

   state_type            state_ff, state_in;
   logic [DW-1:0]        d_ff, d_in;
   logic signed [VW-1:0] v_ff, v_in;
   logic [VW-1:0]        rem_ff, rem_in;
   logic [SCORE_W-1:0]   nsh_ff, nsh_in;
   logic [SCORE_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;

   logic                 v_pos;
   logic [VW-1:0]        v_mag;
   logic                 sat;
   logic [VW:0]          trial;
   logic [VW:0]          diff;
   logic                 fits;

   assign v_mag = v_ff;
   assign v_pos = !v_ff[VW-1] && (v_ff != '0);
   // quotient reaches 2^16 exactly when D >= 32 * V
   assign sat   = {{(VW + SAT_SH - DW){1'b0}}, d_ff} >= {v_mag, {SAT_SH{1'b0}}};
   assign trial = {rem_ff, nsh_ff[SCORE_W-1]};
   assign diff  = trial - {1'b0, v_mag};
   assign fits  = trial >= {1'b0, v_mag};

   always_comb begin
      state_in = state_ff;
      d_in     = d_ff;
      v_in     = v_ff;
      rem_in   = rem_ff;
      nsh_in   = nsh_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               d_in     = dsq;
               v_in     = var_n2;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            if (!v_pos) begin
               quo_in   = '0;
               state_in = D_IDLE;
            end else if (sat) begin
               quo_in   = SCORE_MAX;
               state_in = D_IDLE;
            end else begin
               rem_in   = {{(VW - DW + SAT_SH){1'b0}}, d_ff[DW-1:SAT_SH]};
               nsh_in   = {d_ff[SAT_SH-1:0], {SCALE_SH{1'b0}}};
               quo_in   = '0;
               cnt_in   = STEP_W'(SCORE_W);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in = fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_in = {quo_ff[SCORE_W-2:0], fits};
            nsh_in = {nsh_ff[SCORE_W-2:0], 1'b0};
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      d_ff   <= d_in;
      v_ff   <= v_in;
      rem_ff <= rem_in;
      nsh_ff <= nsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign result.busy     = (state_ff != D_IDLE);
   assign result.quotient = quo_ff;

endmodule

>>> hdl/windowed_zscore_anomaly_detector.sv
// Usage: each req word carries one vibration/temperature pair; each produces
// exactly one rsp word with the combined squared z-score (Q4.12), the anomaly
// flag and the warm-up flag. Registers score_limit (index 0) and min_samples
// (index 1) are written on the csr channel, which is always ready.
// Sequence: a warm-up pair goes straight to S_DONE after acceptance. A scored
// pair walks the n stored pairs of the window (up to 10) through the single
// shared multiplier (S_SQV, S_SQT and S_ACC per stored pair), then runs a
// short multiply sequence per channel and two 16-step serial divisions, the
// first overlapping the second channel's setup.
// Throughput: one pair at a time; req_tready is high only while idle, so a
// pair holds the input until its word is moved into the rsp output register.
// A finished word waits in the rsp output register, so the next pair is
// accepted while the receiver stalls; a second finished word holds inside
// until the first one is taken.
// Reset: synchronous, active high; empties the window and restores the
// register defaults (score_limit 4.0, min_samples 5).
// ----------------------------------------------------------------------------
// windowed_zscore_anomaly_detector
// Sliding-window squared z-score detector over vibration and temperature.
// ----------------------------------------------------------------------------
`include "windowed_zscore_anomaly_detector_defines.svh"

module windowed_zscore_anomaly_detector (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [15:0] vibration_sample, [31:16] temperature_sample
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [zsc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: [15:0] combined_score, [16] anomaly, [23:17] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [zsc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: [0] warming_up
   output logic [0:0]                         rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [zsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [zsc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import zsc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_SQV, S_SQT, S_ACC,
      S_SS, S_NQL, S_NQH, S_NX, S_DEV, S_DD,
      S_DIV_GO, S_WAIT_V, S_WAIT_T, S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   ch_ff, ch_in;
   logic [SMP_W-1:0]       vib_x_ff, vib_x_in;
   logic [SMP_W-1:0]       tmp_x_ff, tmp_x_in;
   logic signed [SUM_W-1:0] sv_ff, sv_in, st_ff, st_in;
   logic [QW-1:0]          qv_ff, qv_in, qt_ff, qt_in;
   logic signed [VW-1:0]   v_ff, v_in;
   logic signed [MW-1:0]   dev_ff, dev_in;
   logic signed [2*MW-1:0] prod_ff;
   logic [SCORE_W-1:0]     term_ff, term_in;
   logic [SCORE_W-1:0]     score_ff, score_in;
   logic                   warm_ff, warm_in;
   logic [SCORE_W-1:0]     limit_ff, limit_in;
   logic [MIN_W-1:0]       min_ff, min_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]     rsp_score_ff, rsp_score_in;
   logic                   rsp_anom_ff, rsp_anom_in;
   logic                   rsp_warm_ff, rsp_warm_in;

   // shared multiplier
   logic                   mul_en;
   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] mul_p;

   logic                   accept;
   logic [RAM_W-1:0]       ram_rd;
   logic [SMP_W-1:0]       rd_vib, rd_tmp;
   logic signed [SUM_W-1:0] rd_vib_s, rd_tmp_s, s_sel;
   logic [QW-1:0]          q_sel;
   logic signed [MW-1:0]   s_mw, x_mw, n_mw, qlo_mw, qhi_mw, rdv_mw, rdt_mw;
   logic [CMP_W-1:0]       cnt_cmp, min_cmp;
   logic [SCORE_W:0]       score_sum;

   logic                   div_start;
   div_result_type         div_res;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // window rings: vibration in the low half, temperature in the high half
   zsc_ram #(.DATA_W(RAM_W), .DEPTH(WINDOW)) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req_tdata),
      .rd_addr (idx_ff[SLOT_W-1:0]),
      .rd_data (ram_rd)
   );

   zsc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .dsq    (prod_ff[DW-1:0]),
      .var_n2 (v_ff),
      .result (div_res)
   );

   assign rd_vib   = ram_rd[SMP_W-1:0];
   assign rd_tmp   = ram_rd[RAM_W-1:SMP_W];
   assign rd_vib_s = {{(SUM_W - SMP_W){1'b0}}, rd_vib};
   assign rd_tmp_s = {{(SUM_W - SMP_W){rd_tmp[SMP_W-1]}}, rd_tmp};
   assign rdv_mw   = {{(MW - SMP_W){1'b0}}, rd_vib};
   assign rdt_mw   = {{(MW - SMP_W){rd_tmp[SMP_W-1]}}, rd_tmp};

   // operands of the channel in progress
   assign s_sel  = ch_ff ? st_ff : sv_ff;
   assign q_sel  = ch_ff ? qt_ff : qv_ff;
   assign s_mw   = {{(MW - SUM_W){s_sel[SUM_W-1]}}, s_sel};
   assign x_mw   = ch_ff ? {{(MW - SMP_W){tmp_x_ff[SMP_W-1]}}, tmp_x_ff}
                         : {{(MW - SMP_W){1'b0}}, vib_x_ff};
   assign n_mw   = {{(MW - CNT_W){1'b0}}, cnt_ff};
   assign qlo_mw = {{(MW - LO_W){1'b0}}, q_sel[LO_W-1:0]};
   assign qhi_mw = {{(MW - HI_W){1'b0}}, q_sel[QW-1:LO_W]};

   assign mul_p  = mul_a * mul_b;

   assign score_sum = {1'b0, term_ff} + {1'b0, div_res.quotient};
   assign min_cmp   = {{(CMP_W - MIN_W){1'b0}}, min_ff};
   assign cnt_cmp   = {{(CMP_W - CNT_W){1'b0}}, cnt_in};

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      ch_in        = ch_ff;
      vib_x_in     = vib_x_ff;
      tmp_x_in     = tmp_x_ff;
      sv_in        = sv_ff;
      st_in        = st_ff;
      qv_in        = qv_ff;
      qt_in        = qt_ff;
      v_in         = v_ff;
      dev_in       = dev_ff;
      term_in      = term_ff;
      score_in     = score_ff;
      warm_in      = warm_ff;
      limit_in     = limit_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_score_in = rsp_score_ff;
      rsp_anom_in  = rsp_anom_ff;
      rsp_warm_in  = rsp_warm_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      // the user must make configuration writes only while idle; the block does not enforce it
      if (csr_valid) begin
         case (csr_index)
            CSR_SCORE_LIMIT: limit_in = csr_data[SCORE_W-1:0];
            CSR_MIN_SAMPLES: min_in   = csr_data[MIN_W-1:0];
            default: begin
            end
         endcase
      end

      // drop the output word once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               vib_x_in = req_tdata[SMP_W-1:0];
               tmp_x_in = req_tdata[REQ_DATA_W-1:SMP_W];
               slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
               cnt_in   = (cnt_ff == CNT_FULL) ? cnt_ff : cnt_ff + CNT_W'(1);
               idx_in   = '0;
               sv_in    = '0;
               st_in    = '0;
               qv_in    = '0;
               qt_in    = '0;
               ch_in    = 1'b0;
               if (cnt_cmp < min_cmp) begin
                  // warm-up: skip scoring entirely
                  score_in = '0;
                  warm_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  warm_in  = 1'b0;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            state_in = S_SQV;
         end
         S_SQV: begin
            mul_en   = 1'b1;
            mul_a    = rdv_mw;
            mul_b    = rdv_mw;
            sv_in    = sv_ff + rd_vib_s;
            state_in = S_SQT;
         end
         S_SQT: begin
            mul_en   = 1'b1;
            mul_a    = rdt_mw;
            mul_b    = rdt_mw;
            st_in    = st_ff + rd_tmp_s;
            qv_in    = qv_ff + prod_ff[QW-1:0];
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_ACC;
         end
         S_ACC: begin
            qt_in = qt_ff + prod_ff[QW-1:0];
            if (idx_ff == cnt_ff) begin
               state_in = S_SS;
            end else begin
               state_in = S_SQV;
            end
         end
         S_SS: begin
            mul_en   = 1'b1;
            mul_a    = s_mw;
            mul_b    = s_mw;
            state_in = S_NQL;
         end
         S_NQL: begin
            v_in     = -prod_ff[VW-1:0];
            mul_en   = 1'b1;
            mul_a    = n_mw;
            mul_b    = qlo_mw;
            state_in = S_NQH;
         end
         S_NQH: begin
            v_in     = v_ff + prod_ff[VW-1:0];
            mul_en   = 1'b1;
            mul_a    = n_mw;
            mul_b    = qhi_mw;
            state_in = S_NX;
         end
         S_NX: begin
            v_in     = v_ff + {prod_ff[VW-LO_W-1:0], {LO_W{1'b0}}};
            mul_en   = 1'b1;
            mul_a    = n_mw;
            mul_b    = x_mw;
            state_in = S_DEV;
         end
         S_DEV: begin
            dev_in   = prod_ff[MW-1:0] - s_mw;
            state_in = S_DD;
         end
         S_DD: begin
            mul_en   = 1'b1;
            mul_a    = dev_ff;
            mul_b    = dev_ff;
            state_in = ch_ff ? S_WAIT_V : S_DIV_GO;
         end
         S_DIV_GO: begin
            // vibration divide runs while the temperature terms are formed
            div_start = 1'b1;
            ch_in     = 1'b1;
            state_in  = S_SS;
         end
         S_WAIT_V: begin
            if (!div_res.busy) begin
               term_in   = div_res.quotient;
               div_start = 1'b1;
               state_in  = S_WAIT_T;
            end
         end
         S_WAIT_T: begin
            if (!div_res.busy) begin
               score_in = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = score_ff;
               rsp_anom_in  = score_ff > limit_ff;
               rsp_warm_in  = warm_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         cnt_ff       <= '0;
         ch_ff        <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         min_ff       <= MIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         cnt_ff       <= cnt_in;
         ch_ff        <= ch_in;
         limit_ff     <= limit_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      vib_x_ff     <= vib_x_in;
      tmp_x_ff     <= tmp_x_in;
      sv_ff        <= sv_in;
      st_ff        <= st_in;
      qv_ff        <= qv_in;
      qt_ff        <= qt_in;
      v_ff         <= v_in;
      dev_ff       <= dev_in;
      term_ff      <= term_in;
      score_ff     <= score_in;
      warm_ff      <= warm_in;
      rsp_score_ff <= rsp_score_in;
      rsp_anom_ff  <= rsp_anom_in;
      rsp_warm_ff  <= rsp_warm_in;
      if (mul_en) begin
         prod_ff <= mul_p;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SCORE_W - 1){1'b0}}, rsp_anom_ff, rsp_score_ff};
   assign rsp_tuser  = rsp_warm_ff;

   `ZSC_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready,
      "input accepted while a pair is still being scored")
   `ZSC_ASSERT_HOLDS(a_warm_zero_score, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata[SCORE_W:0] == '0, "warm-up word carries a score or anomaly")
   `ZSC_ASSERT_HOLDS(a_window_bounds, clock, reset, 1'b1,
      cnt_ff <= CNT_FULL && CNT_W'(slot_ff) < CNT_FULL, "window count or slot out of range")
   `ZSC_ASSERT_HOLDS(a_div_start_idle, clock, reset, div_start, !div_res.busy,
      "divider started while busy")

endmodule
